FILE: sv/isort_pkg.sv
// Shared types and constants for the insertion sorter.
package isort_pkg;

  localparam int unsigned KeyW = 32;

  typedef logic signed [KeyW-1:0] key_t;

  // Per-cycle command that the sequencer broadcasts to every cell.
  typedef struct packed {
    logic ins;       // insert the broadcast key
    logic shift_up;  // take the lower neighbor's entry
    logic shift_dn;  // take the upper neighbor's entry
  } cell_ctrl_t;

endpackage

FILE: sv/isort_if.sv
// Handshake channels for keys entering and sorted keys leaving the sorter.
interface isort_in_if import isort_pkg::*; ();
  logic valid;
  logic ready;
  key_t key;
  logic batch_end;

  modport source (output valid, output key, output batch_end, input ready);
  modport sink   (input valid, input key, input batch_end, output ready);
endinterface

interface isort_out_if import isort_pkg::*; ();
  logic valid;
  logic ready;
  key_t sorted_key;
  logic final_res;
  logic overflowed;

  modport source (output valid, output sorted_key, output final_res, output overflowed,
                  input ready);
  modport sink   (input valid, input sorted_key, input final_res, input overflowed,
                  output ready);
endinterface

FILE: sv/isort_cell.sv
// One slot of the insertion chain: holds a key and trades it with its neighbors.
module isort_cell import isort_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  key_t       key_i,
  input  key_t       lo_key_i,
  input  logic       lo_vld_i,
  input  logic       lo_gt_i,
  input  key_t       hi_key_i,
  input  logic       hi_vld_i,
  output key_t       key_o,
  output logic       vld_o,
  output logic       gt_o
);

  key_t key_q, key_d;
  logic vld_q, vld_d;

  // An empty slot sorts above every key, so a new key lands in the first
  // slot whose neighbor below does not exceed it.
  assign gt_o = !vld_q || (key_q > key_i);

  always_comb begin
    key_d = key_q;
    vld_d = vld_q;
    if (ctrl_i.ins) begin
      if (gt_o) begin
        if (lo_gt_i) begin
          key_d = lo_key_i;
          vld_d = lo_vld_i;
        end else begin
          key_d = key_i;
          vld_d = 1'b1;
        end
      end
    end else if (ctrl_i.shift_up) begin
      key_d = lo_key_i;
      vld_d = lo_vld_i;
    end else if (ctrl_i.shift_dn) begin
      key_d = hi_key_i;
      vld_d = hi_vld_i;
    end
  end

  // Occupancy bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Key storage needs no reset.
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o = key_q;
  assign vld_o = vld_q;

endmodule

FILE: sv/insertion_sorter_top.sv
// Batch insertion sorter built from a chain of compare-and-shift cells.
//
//   channel  dir  handshake      payload
//   in_i     in   valid/ready    key, batch_end
//   out_o    out  valid/ready    sorted_key, final_res, overflowed
//   cfg      in   cfg_we_i       cfg_wdata_i (descending)
//
// A key is inserted in parallel: every cell compares and shifts at once.
// After the word with batch_end, the chain drains one key per accepted output
// word; smallest-first drains from the bottom cell with no lead-in, largest-
// first shifts the chain up until its top cell holds a key before the first
// word. No input is taken while a batch drains. Reset empties the chain at
// once; a stalled output holds the chain once its output end cell has a key.
module insertion_sorter_top import isort_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_wdata_i,
  isort_in_if.sink     in_i,
  isort_out_if.source  out_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic            desc_q;
  logic            drain_q, drain_d;
  logic            ovf_q, ovf_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  cell_ctrl_t      ctrl;
  key_t            cell_key [CAPACITY];
  logic            cell_vld [CAPACITY];
  logic            cell_gt  [CAPACITY];

  logic            full;
  logic            in_fire;
  logic            out_fire;
  logic            last_word;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desc_q <= 1'b0;
    end else if (cfg_we_i) begin
      desc_q <= cfg_wdata_i;
    end
  end

  assign full      = (cnt_q == CntW'(CAPACITY));
  assign in_fire   = in_i.valid && in_i.ready;
  assign out_fire  = out_o.valid && out_o.ready;
  assign last_word = (cnt_q == CntW'(1));

  // Chain commands.
  always_comb begin
    ctrl.ins      = in_fire && !full;
    ctrl.shift_up = drain_q && desc_q && (!cell_vld[CAPACITY-1] || out_o.ready);
    ctrl.shift_dn = drain_q && !desc_q && out_o.ready;
  end

  // Batch bookkeeping.
  always_comb begin
    drain_d = drain_q;
    ovf_d   = ovf_q;
    cnt_d   = cnt_q;
    if (in_fire) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        cnt_d = cnt_q + CntW'(1);
      end
      if (in_i.batch_end) begin
        drain_d = 1'b1;
      end
    end else if (out_fire) begin
      cnt_d = cnt_q - CntW'(1);
      if (last_word) begin
        drain_d = 1'b0;
        ovf_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drain_q <= 1'b0;
      ovf_q   <= 1'b0;
      cnt_q   <= '0;
    end else begin
      drain_q <= drain_d;
      ovf_q   <= ovf_d;
      cnt_q   <= cnt_d;
    end
  end

  // The cell chain; cell 0 holds the smallest key.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    key_t lo_key, hi_key;
    logic lo_vld, lo_gt, hi_vld;

    if (g == 0) begin : g_bot
      assign lo_key = '0;
      assign lo_vld = 1'b0;
      assign lo_gt  = 1'b0;
    end else begin : g_mid_lo
      assign lo_key = cell_key[g-1];
      assign lo_vld = cell_vld[g-1];
      assign lo_gt  = cell_gt[g-1];
    end

    if (g == CAPACITY - 1) begin : g_top
      assign hi_key = '0;
      assign hi_vld = 1'b0;
    end else begin : g_mid_hi
      assign hi_key = cell_key[g+1];
      assign hi_vld = cell_vld[g+1];
    end

    isort_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .key_i    (in_i.key),
      .lo_key_i (lo_key),
      .lo_vld_i (lo_vld),
      .lo_gt_i  (lo_gt),
      .hi_key_i (hi_key),
      .hi_vld_i (hi_vld),
      .key_o    (cell_key[g]),
      .vld_o    (cell_vld[g]),
      .gt_o     (cell_gt[g])
    );
  end

  // Output word comes straight from the end cell of the drain direction.
  assign in_i.ready       = !drain_q;
  assign out_o.valid      = drain_q && (desc_q ? cell_vld[CAPACITY-1] : cell_vld[0]);
  assign out_o.sorted_key = desc_q ? cell_key[CAPACITY-1] : cell_key[0];
  assign out_o.final_res  = last_word;
  assign out_o.overflowed = ovf_q;

endmodule

FILE: sv/isort_chk.sv
// Port-level checks for the insertion sorter, bound to its top level.
module isort_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic in_batch_end,
  input logic out_valid,
  input logic out_ready,
  input logic out_final,
  input logic out_ovf
);

  // No key is taken while a batch is being emitted.
  a_no_in_during_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready)
    else $error("input ready while an output word is pending");

  // The word that closes a batch starts the drain.
  a_batch_end_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready && in_batch_end) |=> !in_ready)
    else $error("input still ready after batch end");

  // The final word ends the batch and frees the input.
  a_final_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_ready && out_final) |=> (!out_valid && in_ready))
    else $error("batch did not end after final word");

  // The overflow mark holds across all words of a batch.
  a_ovf_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_ready && !out_final) |=> $stable(out_ovf))
    else $error("overflow mark changed within a batch");

endmodule

bind insertion_sorter_top isort_chk u_isort_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid     (in_i.valid),
  .in_ready     (in_i.ready),
  .in_batch_end (in_i.batch_end),
  .out_valid    (out_o.valid),
  .out_ready    (out_o.ready),
  .out_final    (out_o.final_res),
  .out_ovf      (out_o.overflowed)
);

FILE: tb/isort_checker.sv
// Checker that predicts the sorted output of each batch and compares every result word.
`timescale 1ns / 1ps

module isort_checker import isort_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  isort_in_if         in_mon,
  isort_out_if        out_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  // One expected result word.
  typedef struct {
    key_t key;
    logic last;
    logic ovf;
  } sorted_word_t;

  sorted_word_t sorted_words_q[$];

  // Private copy of the batch, kept in ascending order like the block's chain.
  key_t        batch_keys [CAPACITY];
  int unsigned batch_fill;
  logic        batch_ovf;
  logic        order_desc;
  int unsigned fails;

  always @(posedge clk_i or negedge rst_ni) begin : track
    sorted_word_t want;
    int unsigned  pos;
    int unsigned  n;
    int unsigned  i;
    if (!rst_ni) begin
      sorted_words_q.delete();
      batch_fill = 0;
      batch_ovf  = 1'b0;
      order_desc = 1'b0;
      fails      = 0;
    end else begin
      if (cfg_we_i) begin
        order_desc = cfg_wdata_i;
      end

      // Compare each accepted result word against the oldest expectation.
      if (out_mon.valid && out_mon.ready) begin
        if (sorted_words_q.size() == 0) begin
          $error("unexpected word: sorted_key %0d final_res %0b overflowed %0b",
                 out_mon.sorted_key, out_mon.final_res, out_mon.overflowed);
          fails++;
        end else begin
          want = sorted_words_q.pop_front();
          if (out_mon.sorted_key !== want.key) begin
            $error("sorted_key: expected %0d, got %0d", want.key, out_mon.sorted_key);
            fails++;
          end
          if (out_mon.final_res !== want.last) begin
            $error("final_res: expected %0b, got %0b", want.last, out_mon.final_res);
            fails++;
          end
          if (out_mon.overflowed !== want.ovf) begin
            $error("overflowed: expected %0b, got %0b", want.ovf, out_mon.overflowed);
            fails++;
          end
        end
      end

      // Insert an accepted key, or drop it once the batch is full.
      if (in_mon.valid && in_mon.ready) begin
        if (batch_fill < CAPACITY) begin
          pos = batch_fill;
          while (pos > 0 && batch_keys[pos-1] > in_mon.key) begin
            batch_keys[pos] = batch_keys[pos-1];
            pos--;
          end
          batch_keys[pos] = in_mon.key;
          batch_fill++;
        end else begin
          batch_ovf = 1'b1;
        end

        // The closing key releases the whole batch in the selected order.
        if (in_mon.batch_end) begin
          n = batch_fill;
          for (i = 0; i < n; i++) begin
            want.key  = order_desc ? batch_keys[n-1-i] : batch_keys[i];
            want.last = (i + 1 == n);
            want.ovf  = batch_ovf;
            sorted_words_q.push_back(want);
          end
          batch_fill = 0;
          batch_ovf  = 1'b0;
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= sorted_words_q.size();
  end

endmodule

FILE: tb/insertion_sorter_top_tb.sv
// Testbench top for the insertion sorter: stimulus, output stalls and the verdict.
`timescale 1ns / 1ps

module insertion_sorter_top_tb import isort_pkg::*; ();

  localparam int unsigned CAPACITY     = 64;
  localparam int unsigned SETTLE       = 8;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned RANDOM_ITEMS = 107;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  localparam key_t KEY_MAX = 32'sh7FFF_FFFF;
  localparam key_t KEY_MIN = 32'sh8000_0000;
  localparam key_t EDGE_KEYS [7] = '{KEY_MAX, KEY_MIN, -1, 0, 1, KEY_MIN, KEY_MAX};

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_wdata;
  logic        hold_req;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned burst_left;
  int unsigned sent_items;
  key_t        batch_q[$];

  isort_in_if  in_ch ();
  isort_out_if out_ch ();

  insertion_sorter_top #(
    .CAPACITY (CAPACITY)
  ) u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  isort_checker #(
    .CAPACITY (CAPACITY)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog on the total run length.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  // Receiver: changes its stall pattern now and then, and holds off once for a long time.
  initial begin : sink_side
    int unsigned mode;
    int unsigned span;
    int unsigned held;
    logic        hold_taken;
    hold_taken = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 120);
      repeat (span) begin
        if (hold_req && !hold_taken) begin
          hold_taken = 1'b1;
          out_ch.ready <= 1'b0;
          for (held = 0; held < LONG_HOLD; held++) @(posedge clk);
        end else begin
          case (mode)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= ($urandom_range(0, 1) == 0);
            2: out_ch.ready <= ($urandom_range(0, 4) == 0);
            default: out_ch.ready <= ($urandom_range(0, 7) != 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // Random key: full range, a narrow band that repeats often, or an extreme value.
  function automatic key_t pick_key();
    key_t k;
    case ($urandom_range(0, 3))
      0: k = key_t'($urandom_range(0, 15)) - 8;
      1: k = EDGE_KEYS[$urandom_range(0, 6)];
      default: k = $urandom;
    endcase
    return k;
  endfunction

  // Offer one word and hold it until accepted; gaps come between bursts.
  task automatic send_word(input key_t k, input logic last);
    int unsigned gap;
    in_ch.valid     <= 1'b1;
    in_ch.key       <= k;
    in_ch.batch_end <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
      gap = $urandom_range(1, 6);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  // Wait until every expected word has come and the block has settled.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_order(input logic desc);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= desc;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic fill_batch(input int unsigned n);
    batch_q.delete();
    repeat (n) batch_q.push_back(pick_key());
  endtask

  // Send the queued batch; a nonzero split changes the order before that word.
  task automatic send_batch(input int unsigned split, input logic split_desc);
    int unsigned i;
    for (i = 0; i < batch_q.size(); i++) begin
      if (split != 0 && i == split) begin
        write_order(split_desc);
      end
      send_word(batch_q[i], i + 1 == batch_q.size());
    end
    sent_items += batch_q.size();
  endtask

  // Stimulus and verdict.
  initial begin : source_side
    int unsigned n;
    int unsigned split;
    int unsigned o;
    int unsigned i;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= 1'b0;
    hold_req        <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.key       <= '0;
    in_ch.batch_end <= 1'b0;
    burst_left = 0;
    sent_items = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: a lone key, extremes with duplicates in both orders,
    // an already sorted batch, and an order change in the middle of a batch.
    write_order(1'b0);
    batch_q.delete();
    batch_q.push_back(0);
    send_batch(0, 1'b0);
    for (o = 0; o < 2; o++) begin
      write_order(o[0]);
      batch_q.delete();
      foreach (EDGE_KEYS[j]) batch_q.push_back(EDGE_KEYS[j]);
      send_batch(0, 1'b0);
    end
    batch_q.delete();
    for (i = 1; i <= 4; i++) batch_q.push_back(i);
    send_batch(0, 1'b0);
    batch_q.delete();
    batch_q.push_back(10);
    batch_q.push_back(-10);
    batch_q.push_back(0);
    batch_q.push_back(7);
    send_batch(3, 1'b0);

    // Random: a short batch under a long output stall with the next batch
    // waiting behind it, an overflowing batch whose closing word is itself
    // dropped, then mostly short batches.
    sent_items = 0;
    write_order(1'($urandom_range(0, 1)));
    hold_req <= 1'b1;
    fill_batch(8);
    send_batch(0, 1'b0);
    fill_batch(CAPACITY + 1 + $urandom_range(0, 3));
    send_batch(0, 1'b0);
    while (sent_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        write_order(1'($urandom_range(0, 1)));
      end
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, CAPACITY) : $urandom_range(1, 8);
      fill_batch(n);
      split = (n > 1 && $urandom_range(0, 4) == 0) ? $urandom_range(1, n - 1) : 0;
      send_batch(split, 1'($urandom_range(0, 1)));
    end

    // Drain, then leave room for any stray word.
    wait_idle();
    repeat (CAPACITY + SETTLE) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/isort_pkg.sv
sv/isort_if.sv
sv/isort_cell.sv
sv/insertion_sorter_top.sv
sv/isort_chk.sv
tb/isort_checker.sv
tb/insertion_sorter_top_tb.sv
